// ----- rtl/core/iosa_pkg.sv -----
// ----------------------------------------------------------------------------
// iosa_pkg
// Shared types, constants and helpers of the incremental OSA edit distance.
// ----------------------------------------------------------------------------
package iosa_pkg;

  localparam int IOSA_MAX_REF = 64;
  localparam logic [15:0] SAT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    FN_LOAD    = 2'd0,
    FN_RESTART = 2'd1,
    FN_PUSH    = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    CFG_REF_LENGTH  = 3'd0,
    CFG_INSERT_COST = 3'd1,
    CFG_DELETE_COST = 3'd2,
    CFG_SUBST_COST  = 3'd3,
    CFG_SWAP_COST   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESTART,
    ST_PUSH,
    ST_CHECK,
    ST_SCAN
  } state_t;

  // operands of one DP cell update
  typedef struct packed {
    logic        first;     // column zero
    logic        match;     // reference char equals target char
    logic        trans_ok;  // transposition applies
    logic [15:0] left;      // current row, column j-1
    logic [15:0] up;        // previous row, column j
    logic [15:0] diag;      // previous row, column j-1
    logic [15:0] back2;     // row two up, column j-2
    logic [3:0]  ins_cost;
    logic [3:0]  del_cost;
    logic [3:0]  sub_cost;
    logic [3:0]  swp_cost;
  } cell_in_t;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [3:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {13'd0, b};
    return s[16] ? SAT_MAX : s[15:0];
  endfunction

  function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ----- rtl/core/iosa_cell.sv -----
// ----------------------------------------------------------------------------
// iosa_cell
// One DP cell: min of insertion, deletion, substitution and transposition.
// ----------------------------------------------------------------------------
module iosa_cell
  import iosa_pkg::*;
(
  input  cell_in_t    cin,
  output logic [15:0] value
);

  logic [15:0] ins_v, del_v, sub_v, swp_v, best;

  always_comb begin
    ins_v = sat_add(cin.left, cin.ins_cost);
    del_v = sat_add(cin.up, cin.del_cost);
    sub_v = sat_add(cin.diag, cin.match ? 4'd0 : cin.sub_cost);
    swp_v = sat_add(cin.back2, cin.swp_cost);
    best  = min16(min16(ins_v, del_v), sub_v);
    if (cin.trans_ok) begin
      best = min16(best, swp_v);
    end
    if (cin.first) begin
      value = sat_add(cin.up, 4'd1);
    end else begin
      value = best;
    end
  end

endmodule

// ----- rtl/core/iosa_dpmem.sv -----
// ----------------------------------------------------------------------------
// iosa_dpmem
// DP row ring store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module iosa_dpmem #(
  parameter int DEPTH = 195,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] ra_addr,
  output logic [15:0]   ra_data,
  input  logic [AW-1:0] rb_addr,
  output logic [15:0]   rb_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// ----- rtl/core/incremental_osa_edit_distance.sv -----
// ----------------------------------------------------------------------------
// incremental_osa_edit_distance
// Streaming restricted Damerau-Levenshtein (OSA) distance against a stored
// reference, one DP row per pushed target character.
// ----------------------------------------------------------------------------
// Usage: load reference chars (tuser = load), set ref_length and costs over the
// cfg channel while idle, send a restart, then push target chars. Every input
// transfer returns one output transfer: distance (cell L of the newest row) and
// the minimum over cells 0..L of the up to three stored rows, saturated at
// 65535. A push sweeps one row through the DP store, one cell per cycle on its
// two read ports plus a write port. A restart fills row 0 with a clearing pass
// over columns 0..MAX_REF. Load and unused items go straight to the check.
// After ref_length is changed, each stored row whose cached minimum was taken
// at another length is rescanned once. The output register lets the next item
// enter while a result waits; a finished result stalls only if the previous
// one is still held.
module incremental_osa_edit_distance
  import iosa_pkg::*;
#(
  parameter int MAX_REF = IOSA_MAX_REF
) (
  input  logic        clk,
  input  logic        rst,
  // cfg write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [5:0] ref_index, [13:6] char_value, [15:14] zero
  input  logic [1:0]  s_tuser,   // [1:0] func
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [15:0] distance, [31:16] min_distance
);

  localparam int ROW_W = MAX_REF + 1;
  localparam int DEPTH = 3 * ROW_W;
  localparam int LW    = $clog2(MAX_REF + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = (MAX_REF > 1) ? $clog2(MAX_REF) : 1;

  function automatic logic [AW-1:0] row_base(input logic [1:0] row);
    case (row)
      2'd1:    return AW'(ROW_W);
      2'd2:    return AW'(2 * ROW_W);
      default: return '0;
    endcase
  endfunction

  // config registers
  logic [6:0] ref_length;
  logic [3:0] insert_cost, delete_cost, subst_cost, swap_cost;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_length  <= '0;
      insert_cost <= 4'd1;
      delete_cost <= 4'd1;
      subst_cost  <= 4'd1;
      swap_cost   <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REF_LENGTH:  ref_length  <= cfg_data;
        CFG_INSERT_COST: insert_cost <= cfg_data[3:0];
        CFG_DELETE_COST: delete_cost <= cfg_data[3:0];
        CFG_SUBST_COST:  subst_cost  <= cfg_data[3:0];
        CFG_SWAP_COST:   swap_cost   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // length in use, clamped to MAX_REF
  logic [LW-1:0] len;
  always_comb begin
    if (32'(ref_length) > MAX_REF) begin
      len = LW'(MAX_REF);
    end else begin
      len = LW'(ref_length);
    end
  end

  // control and datapath state
  state_t        state, state_next;
  logic [LW-1:0] j;          // issue column
  logic          iss;        // issue active
  logic          vld_d;      // stage 2 valid
  logic [LW-1:0] j_d;
  logic          last_d;
  logic [15:0]   cur_last, prev_last, acc;
  logic [7:0]    ref_last, push_chr, prev_char;
  logic          chars_seen;
  logic [1:0]    rows_valid, row_pointer, scan_row;
  logic [15:0]   row_min [3];
  logic [15:0]   row_end [3];
  logic [LW-1:0] row_len [3];
  logic [15:0]   out_dist, out_min;

  logic accept_in;
  assign s_tready  = (state == ST_IDLE);
  assign accept_in = s_tvalid && s_tready;

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  logic [1:0] prev_row, cur_row, back2_row;
  assign prev_row  = row_pointer;
  assign cur_row   = (row_pointer == 2'd2) ? 2'd0 : row_pointer + 2'd1;
  assign back2_row = (row_pointer == 2'd0) ? 2'd2 : row_pointer - 2'd1;

  // rows whose cached min/end were taken at a different length
  logic [2:0] bad;
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      bad[r] = (r < 32'(rows_valid)) && (row_len[r] != len);
    end
  end

  logic [1:0] bad_row;
  always_comb begin
    if (bad[0]) begin
      bad_row = 2'd0;
    end else if (bad[1]) begin
      bad_row = 2'd1;
    end else begin
      bad_row = 2'd2;
    end
  end

  logic [15:0] min_all;
  always_comb begin
    min_all = SAT_MAX;
    for (int r = 0; r < 3; r++) begin
      if (r < 32'(rows_valid)) begin
        min_all = min16(min_all, row_min[r]);
      end
    end
  end

  // reference store
  logic [7:0]    ref_mem [MAX_REF];
  logic [7:0]    ref_q;
  logic [RW-1:0] ref_raddr;
  logic          ref_we;

  assign ref_we    = accept_in && (s_tuser == FN_LOAD) && (32'(s_tdata[5:0]) < MAX_REF);
  assign ref_raddr = RW'(j - LW'(1));

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[RW'(s_tdata[5:0])] <= s_tdata[13:6];
    end
    ref_q <= ref_mem[ref_raddr];
  end

  // DP store
  logic          dp_we;
  logic [AW-1:0] dp_waddr, ra_addr, rb_addr;
  logic [15:0]   dp_wdata, qa, qb, cell_val;

  assign ra_addr = row_base((state == ST_SCAN) ? scan_row : prev_row) + AW'(j);
  assign rb_addr = row_base(back2_row) + ((j < LW'(2)) ? '0 : AW'(j - LW'(2)));

  always_comb begin
    dp_we    = 1'b0;
    dp_waddr = row_base(cur_row) + AW'(j_d);
    dp_wdata = cell_val;
    if (state == ST_RESTART) begin
      dp_we    = 1'b1;
      dp_waddr = AW'(j);
      dp_wdata = 16'(j);
    end else if (state == ST_PUSH && vld_d) begin
      dp_we = 1'b1;
    end
  end

  iosa_dpmem #(.DEPTH(DEPTH), .AW(AW)) u_dpmem (
    .clk     (clk),
    .we      (dp_we),
    .waddr   (dp_waddr),
    .wdata   (dp_wdata),
    .ra_addr (ra_addr),
    .ra_data (qa),
    .rb_addr (rb_addr),
    .rb_data (qb)
  );

  cell_in_t cin;
  always_comb begin
    cin.first    = (j_d == '0);
    cin.match    = (ref_q == push_chr);
    cin.trans_ok = chars_seen && (j_d > LW'(1)) && (ref_q == prev_char)
                   && (ref_last == push_chr);
    cin.left     = cur_last;
    cin.up       = qa;
    cin.diag     = prev_last;
    cin.back2    = qb;
    cin.ins_cost = insert_cost;
    cin.del_cost = delete_cost;
    cin.sub_cost = subst_cost;
    cin.swp_cost = swap_cost;
  end

  iosa_cell u_cell (
    .cin   (cin),
    .value (cell_val)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_in) begin
          case (s_tuser)
            FN_RESTART: state_next = ST_RESTART;
            FN_PUSH:    state_next = ST_PUSH;
            default:    state_next = ST_CHECK;
          endcase
        end
      end
      ST_RESTART: if (j == LW'(MAX_REF)) state_next = ST_CHECK;
      ST_PUSH:    if (vld_d && last_d) state_next = ST_CHECK;
      ST_SCAN:    if (vld_d && last_d) state_next = ST_CHECK;
      ST_CHECK: begin
        if (bad != '0) begin
          state_next = ST_SCAN;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      iss         <= 1'b0;
      vld_d       <= 1'b0;
      chars_seen  <= 1'b0;
      prev_char   <= '0;
      rows_valid  <= 2'd1;
      row_pointer <= '0;
      m_tvalid    <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        row_len[r] <= '0;
      end
    end else begin
      // a result posted in CHECK takes over the slot freed by this transfer
      if (m_tvalid && m_tready && !(state == ST_CHECK && bad == '0)) begin
        m_tvalid <= 1'b0;
      end
      vld_d  <= iss && (state == ST_PUSH || state == ST_SCAN);
      j_d    <= j;
      last_d <= (j == len);
      if (iss && (state == ST_PUSH || state == ST_SCAN)) begin
        j <= j + LW'(1);
        if (j == len) begin
          iss <= 1'b0;
        end
      end
      case (state)
        ST_IDLE: begin
          if (accept_in) begin
            j        <= '0;
            iss      <= (s_tuser == FN_PUSH);
            acc      <= SAT_MAX;
            push_chr <= s_tdata[13:6];
          end
        end
        ST_RESTART: begin
          j <= j + LW'(1);
          if (j == LW'(MAX_REF)) begin
            row_min[0]  <= '0;
            row_end[0]  <= 16'(len);
            row_len[0]  <= len;
            row_pointer <= '0;
            rows_valid  <= 2'd1;
            chars_seen  <= 1'b0;
            prev_char   <= '0;
          end
        end
        ST_PUSH: begin
          if (vld_d) begin
            cur_last  <= cell_val;
            prev_last <= qa;
            ref_last  <= ref_q;
            acc       <= min16(acc, cell_val);
            if (last_d) begin
              row_min[cur_row] <= min16(acc, cell_val);
              row_end[cur_row] <= cell_val;
              row_len[cur_row] <= len;
              row_pointer      <= cur_row;
              if (rows_valid != 2'd3) begin
                rows_valid <= rows_valid + 2'd1;
              end
              prev_char  <= push_chr;
              chars_seen <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (vld_d) begin
            acc <= min16(acc, qa);
            if (last_d) begin
              row_min[scan_row] <= min16(acc, qa);
              row_end[scan_row] <= qa;
              row_len[scan_row] <= len;
            end
          end
        end
        ST_CHECK: begin
          if (bad != '0) begin
            scan_row <= bad_row;
            j        <= '0;
            iss      <= 1'b1;
            acc      <= SAT_MAX;
          end else if (out_free) begin
            out_dist <= row_end[row_pointer];
            out_min  <= min_all;
            m_tvalid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {out_min, out_dist};

  // assertions
  a_rows_valid_range: assert property (@(posedge clk) disable iff (rst)
    rows_valid != 2'd0)
    else $error("rows_valid left 1..3");

  a_write_not_read_rows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH && vld_d) |-> (cur_row != prev_row && cur_row != back2_row))
    else $error("row write collides with a row being read");

  a_last_at_len: assert property (@(posedge clk) disable iff (rst)
    (vld_d && last_d) |-> (j_d == len))
    else $error("sweep ended off the last column");

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && bad == '0 && out_free) |=> (m_tvalid && state == ST_IDLE))
    else $error("finished item did not post a result");

  a_no_stage2_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!vld_d && !iss))
    else $error("sweep still active while idle");

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for incremental_osa_edit_distance. It walks a short
// stimulus table and then runs random phases of loads, restarts, pushes and
// unused items, each phase under its own length and cost settings. Every result
// transfer is compared against table values or an in-bench OSA row predictor.
// ----------------------------------------------------------------------------
module testbench
  import iosa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NREF  = IOSA_MAX_REF;
  localparam int NPH   = 10;
  localparam int PH_N  = 165;
  localparam logic [1:0] FN_NONE = 2'd3;   // unused func code

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [6:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [5:0] ref_index, [13:6] char_value, [15:14] zero
  logic [1:0]  s_tuser;   // [1:0] func
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [15:0] distance, [31:16] min_distance

  incremental_osa_edit_distance dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("** incremental_osa_edit_distance: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  typedef struct {
    logic [15:0] distance;
    logic [15:0] mind;
  } answer_t;

  answer_t answers_due[$];

  // mirrored registers
  int len_reg, c_ins, c_del, c_sub, c_swp;
  // mirrored DP ring and reference store
  int       ring [3][NREF+1];
  bit [7:0] ref_mem [NREF];
  bit [7:0] last_ch;
  int       cur_row, rows_filled;
  bit       have_prev;

  int errors, n_items, n_results, n_push, n_restart, n_load, n_cfg;

  function automatic int sat16(int a, int b);
    return (a + b > 65535) ? 65535 : a + b;
  endfunction

  function automatic int min_i(int a, int b);
    return (a < b) ? a : b;
  endfunction

  // applies one item to the mirrored state, returns the answer it causes
  task automatic osa_advance(input logic [1:0] fn, input logic [5:0] idx,
                             input logic [7:0] ch, output answer_t ans);
    int len, prv, cur, bk, best, j, r, m;
    len = (len_reg > NREF) ? NREF : len_reg;   // long length clamps
    if (fn == FN_LOAD) begin
      ref_mem[idx] = ch;
      n_load++;
    end else if (fn == FN_RESTART) begin
      for (j = 0; j <= NREF; j++) ring[0][j] = j;
      cur_row = 0; rows_filled = 1; have_prev = 0; last_ch = 8'd0;
      n_restart++;
    end else if (fn == FN_PUSH) begin
      prv = cur_row;
      cur = (prv + 1) % 3;
      bk  = (prv + 2) % 3;
      cur_row = cur;
      if (rows_filled < 3) rows_filled++;
      ring[cur][0] = sat16(ring[prv][0], 1);   // column zero: above plus one
      for (j = 1; j <= len; j++) begin
        best = sat16(ring[cur][j-1], c_ins);
        best = min_i(best, sat16(ring[prv][j], c_del));
        best = min_i(best, sat16(ring[prv][j-1], (ref_mem[j-1] == ch) ? 0 : c_sub));
        // transposition needs an earlier target char and column >= 2
        if (have_prev && j > 1 && ref_mem[j-1] == last_ch && ref_mem[j-2] == ch)
          best = min_i(best, sat16(ring[bk][j-2], c_swp));
        ring[cur][j] = best;
      end
      last_ch = ch;
      have_prev = 1;
      n_push++;
    end
    // unused func changes nothing, but still answers
    m = 65535;
    for (r = 0; r < rows_filled; r++)
      for (j = 0; j <= len; j++) m = min_i(m, ring[r][j]);
    ans.distance = ring[cur_row][len][15:0];
    ans.mind = m[15:0];
  endtask

  // ---------------------------------------------------------------- sender side
  bit quiet;       // no idling in the closing phase
  bit hold_req;    // asks the receiver for one long hold-off
  int hold_left, rx_burst;

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic [1:0] fn, input logic [5:0] idx,
                           input logic [7:0] ch, input bit typed,
                           input logic [15:0] td, input logic [15:0] tm);
    answer_t a;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, ch, idx};
    s_tuser  <= fn;
    do @(posedge clk); while (!s_tready);
    osa_advance(fn, idx, ch, a);
    if (typed) begin
      a.distance = td;
      a.mind = tm;
    end
    answers_due.push_back(a);
    n_items++;
    @(negedge clk);
  endtask

  // stop offering and wait for every answer; only then is the block idle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // valid stays high across back-to-back writes; caller lowers it
  task automatic cfg_write(input cfg_idx_t i, input logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= i;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (i)
      CFG_REF_LENGTH:  len_reg = v;
      CFG_INSERT_COST: c_ins = v[3:0];
      CFG_DELETE_COST: c_del = v[3:0];
      CFG_SUBST_COST:  c_sub = v[3:0];
      CFG_SWAP_COST:   c_swp = v[3:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
  endtask

  task automatic set_regs(input int l, input int ci, input int cd, input int cs, input int cw);
    cfg_write(CFG_REF_LENGTH, l[6:0]);
    cfg_write(CFG_INSERT_COST, {3'd0, ci[3:0]});
    cfg_write(CFG_DELETE_COST, {3'd0, cd[3:0]});
    cfg_write(CFG_SUBST_COST, {3'd0, cs[3:0]});
    cfg_write(CFG_SWAP_COST, {3'd0, cw[3:0]});
    cfg_valid <= 1'b0;
  endtask

  // narrow alphabet most of the time so matches and swaps really occur
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 9) < 7) return 8'h61 + 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      send_item(FN_LOAD, 6'($urandom_range(0, 63)), pick_char(), 0, 0, 0);
    else if (r < 16)
      send_item(FN_RESTART, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)), 0, 0, 0);
    else if (r < 20)
      send_item(FN_NONE, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)), 0, 0, 0);
    else
      send_item(FN_PUSH, 6'($urandom_range(0, 63)), pick_char(), 0, 0, 0);
  endtask

  // ---------------------------------------------------------------- directed table
  typedef struct {
    logic [1:0]  fn;
    logic [5:0]  idx;
    logic [7:0]  ch;
    bit          typed;
    logic [15:0] d;
    logic [15:0] m;
  } step_t;

  // reset settings: length 0, all costs 1
  step_t steps [] = '{
    '{FN_RESTART, 6'd0,  8'd0,   1, 16'd0, 16'd0},
    '{FN_LOAD,    6'd0,  8'h00,  1, 16'd0, 16'd0},
    '{FN_LOAD,    6'd63, 8'hFF,  1, 16'd0, 16'd0},
    '{FN_PUSH,    6'd0,  8'h00,  1, 16'd1, 16'd0},
    '{FN_PUSH,    6'd63, 8'hFF,  1, 16'd2, 16'd0},
    '{FN_PUSH,    6'd21, 8'hAA,  1, 16'd3, 16'd1},   // ring wraps onto row 0
    '{FN_NONE,    6'd42, 8'h55,  1, 16'd3, 16'd1},   // unused func
    '{FN_RESTART, 6'd63, 8'hFF,  1, 16'd0, 16'd0},
    '{FN_PUSH,    6'd0,  8'h55,  0, 16'd0, 16'd0},
    '{FN_NONE,    6'd0,  8'h00,  0, 16'd0, 16'd0},
    '{FN_LOAD,    6'd31, 8'h80,  0, 16'd0, 16'd0}
  };

  // ---------------------------------------------------------------- main
  initial begin
    int p, k;
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    len_reg = 0; c_ins = 1; c_del = 1; c_sub = 1; c_swp = 1;
    cur_row = 0; rows_filled = 1; have_prev = 0; last_ch = 8'd0;
    for (int r = 0; r < 3; r++) for (int j = 0; j <= NREF; j++) ring[r][j] = 0;
    for (int j = 0; j < NREF; j++) ref_mem[j] = 8'd0;
    errors = 0; n_items = 0; n_results = 0; n_push = 0; n_restart = 0;
    n_load = 0; n_cfg = 0; quiet = 0; hold_req = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (steps[i])
      send_item(steps[i].fn, steps[i].idx, steps[i].ch, steps[i].typed, steps[i].d, steps[i].m);

    for (p = 0; p < NPH; p++) begin
      drain();
      case (p)
        0: set_regs(64, 1, 1, 1, 1);          // full reference
        1: set_regs(0, 0, 0, 0, 0);           // empty reference, free edits
        2: set_regs(127, 15, 15, 15, 15);     // long length clamps to 64
        default: begin
          if ($urandom_range(0, 3) == 0) k = $urandom_range(0, 127);
          else k = $urandom_range(1, 12);
          set_regs(k, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 15), $urandom_range(0, 15));
        end
      endcase
      if (p == NPH - 1) quiet = 1;
      // restart first: rows written at a shorter length are never read
      send_item(FN_RESTART, 6'd0, 8'd0, 0, 0, 0);
      if (p == 0)
        for (k = 0; k < NREF; k++) send_item(FN_LOAD, k[5:0], pick_char(), 0, 0, 0);
      for (k = 0; k < PH_N; k++) begin
        if (p == 2 && k == 20) hold_req = 1;   // receiver stalls, input backs up
        if (p == 3 && k == 60) drain();        // sender waits for all answers
        random_item();
      end
    end

    s_tvalid <= 1'b0;
    k = 0;
    while (answers_due.size() != 0) begin
      @(negedge clk);
      k++;
      if (k > 200000) begin
        $display("** incremental_osa_edit_distance: FAILED **");
        $finish;
      end
    end
    repeat (100) @(negedge clk);
    $display("Ran %0d items (%0d pushes, %0d restarts, %0d loads), %0d results checked,",
             n_items, n_push, n_restart, n_load, n_results);
    $display("%0d register writes over %0d cost/length settings.", n_cfg, NPH + 1);
    if (errors == 0 && answers_due.size() == 0)
      $display("** incremental_osa_edit_distance: PASSED **");
    else
      $display("** incremental_osa_edit_distance: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    m_tready = 1'b0;
    hold_left = 0;
    rx_burst = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_burst > 0) begin
        rx_burst--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rx_burst = $urandom_range(1, 4) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // result check: each transfer against the oldest expectation
  always @(posedge clk) begin
    answer_t a;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (answers_due.size() == 0) begin
        $error("result transfer with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        a = answers_due.pop_front();
        if (m_tdata[15:0] !== a.distance) begin
          $error("distance: expected %0d, actual %0d", a.distance, m_tdata[15:0]);
          errors++;
        end
        if (m_tdata[31:16] !== a.mind) begin
          $error("min_distance: expected %0d, actual %0d", a.mind, m_tdata[31:16]);
          errors++;
        end
      end
    end
  end

endmodule
